// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the UTF-8 stream decoder.
// The macros expect a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CHECK(label, !(cond), msg)

`endif

// ===== src/utf8d_pkg.sv =====
// Package for the UTF-8 stream decoder: byte masks, the job type passed from
// the front end to the back end, and the job queue dimensions. No dependencies.
package utf8d_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] Replacement = 21'h00FFFD;

  localparam logic [7:0] MaskC0 = 8'hC0;
  localparam logic [7:0] MaskE0 = 8'hE0;
  localparam logic [7:0] MaskF0 = 8'hF0;
  localparam logic [7:0] MaskF8 = 8'hF8;
  localparam logic [7:0] ContTag = 8'h80;
  localparam logic [7:0] Lead2Tag = 8'hC0;
  localparam logic [7:0] Lead3Tag = 8'hE0;
  localparam logic [7:0] Lead4Tag = 8'hF0;
  localparam logic [7:0] Payload6 = 8'h3F;
  localparam logic [7:0] Payload5 = 8'h1F;
  localparam logic [7:0] Payload4 = 8'h0F;
  localparam logic [7:0] Payload3 = 8'h07;

  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] Len2 = 3'd2;
  localparam logic [2:0] Len3 = 3'd3;
  localparam logic [2:0] Len4 = 3'd4;

  // Queue depth must be a power of two so that the pointers wrap by themselves.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  // One job: a number of replacement results, then an optional tail result.
  typedef struct packed {
    logic [1:0]     rep;
    logic           tail_v;
    logic           tail_bad;
    logic [CpW-1:0] tail_cp;
  } job_t;

  // Handshake between the queue and the back end.
  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

// ===== src/utf8d_front.sv =====
// Front end of the UTF-8 stream decoder: holds the pending sequence state and
// turns each accepted byte into at most one job. Depends on utf8d_pkg.
module utf8d_front import utf8d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_text_i,
  output job_t       job_o,
  output logic       job_v_o
);

  logic [2:0]     exp_q, exp_d;
  logic [1:0]     cnt_q, cnt_d;
  logic [CpW-1:0] part_q, part_d;

  logic           is_cont;
  logic [2:0]     seen;
  logic [CpW-1:0] val;
  logic [1:0]     brk_cnt;
  logic [2:0]     lead_len;
  logic [CpW-1:0] lead_val;
  job_t           job;

  always_comb begin
    is_cont = (data_byte_i & MaskC0) == ContTag;
    seen = {1'b0, cnt_q} + 3'd1;
    val = {part_q[CpW-7:0], data_byte_i[5:0]};
    brk_cnt = (cnt_q > 2'd2) ? 2'd2 : cnt_q;

    lead_len = LenNone;
    lead_val = '0;
    if ((data_byte_i & MaskE0) == Lead2Tag) begin
      lead_len = Len2;
      lead_val = CpW'(data_byte_i & Payload5);
    end else if ((data_byte_i & MaskF0) == Lead3Tag) begin
      lead_len = Len3;
      lead_val = CpW'(data_byte_i & Payload4);
    end else if ((data_byte_i & MaskF8) == Lead4Tag) begin
      lead_len = Len4;
      lead_val = CpW'(data_byte_i & Payload3);
    end

    exp_d = exp_q;
    cnt_d = cnt_q;
    part_d = part_q;
    job = '0;

    if (exp_q != LenNone && is_cont) begin
      if (seen + 3'd1 >= exp_q) begin
        job.tail_v = 1'b1;
        job.tail_cp = val;
        exp_d = LenNone;
        cnt_d = '0;
        part_d = '0;
      end else if (end_of_text_i) begin
        job.rep = 2'(seen + 3'd1);
      end else begin
        cnt_d = seen[1:0];
        part_d = val;
      end
    end else begin
      if (exp_q != LenNone) begin
        job.rep = brk_cnt + 2'd1;
        exp_d = LenNone;
        cnt_d = '0;
        part_d = '0;
      end
      job.tail_v = 1'b1;
      if (!data_byte_i[7]) begin
        job.tail_cp = CpW'(data_byte_i);
      end else if (lead_len == LenNone || end_of_text_i) begin
        job.tail_cp = Replacement;
        job.tail_bad = 1'b1;
      end else begin
        job.tail_v = 1'b0;
        exp_d = lead_len;
        cnt_d = '0;
        part_d = lead_val;
      end
    end

    if (end_of_text_i) begin
      exp_d = LenNone;
      cnt_d = '0;
      part_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= LenNone;
      cnt_q <= '0;
      part_q <= '0;
    end else if (take_i) begin
      exp_q <= exp_d;
      cnt_q <= cnt_d;
      part_q <= part_d;
    end
  end

  assign job_o = job;
  assign job_v_o = take_i && (job.rep != 2'd0 || job.tail_v);

endmodule

// ===== src/utf8d_queue.sv =====
// Job queue between the front end and the back end of the UTF-8 stream
// decoder, a small register file with wrapping pointers. Depends on utf8d_pkg.
module utf8d_queue import utf8d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_i,
  input  job_t      wr_job_i,
  input  logic      rd_i,
  output job_t      rd_job_o,
  output q_status_t status_o
);

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  assign rd_job_o = mem_q[rd_ptr_q];
  assign status_o.valid = cnt_q != '0;
  assign status_o.full = cnt_q == QCntW'(QDepth);

endmodule

// ===== src/utf8d_back.sv =====
// Back end of the UTF-8 stream decoder: expands each job into its results and
// holds the oldest result in an output register. Depends on utf8d_pkg.
module utf8d_back import utf8d_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  job_t           job_i,
  input  q_status_t      q_status_i,
  output logic           q_rd_o,
  input  logic           pop,
  output logic           empty,
  output logic [CpW-1:0] code_point_o,
  output logic           malformed_o,
  output logic           last_of_run_o
);

  logic [1:0]     idx_q, idx_d;
  logic           out_v_q;
  logic [CpW-1:0] cp_q;
  logic           bad_q, last_q;

  logic           room, advance, in_rep, last;
  logic [CpW-1:0] cp_d;
  logic           bad_d;

  always_comb begin
    room = !out_v_q || pop;
    advance = q_status_i.valid && room;
    in_rep = idx_q < job_i.rep;
    cp_d = in_rep ? Replacement : job_i.tail_cp;
    bad_d = in_rep ? 1'b1 : job_i.tail_bad;
    last = in_rep ? ({1'b0, idx_q} + 3'd1 == {1'b0, job_i.rep}) && !job_i.tail_v : 1'b1;
    idx_d = idx_q;
    if (advance) begin
      idx_d = last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (advance) begin
        out_v_q <= 1'b1;
      end else if (pop) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cp_q <= cp_d;
      bad_q <= bad_d;
      last_q <= last;
    end
  end

  assign q_rd_o = advance && last;
  assign empty = !out_v_q;
  assign code_point_o = cp_q;
  assign malformed_o = bad_q;
  assign last_of_run_o = last_q;

endmodule

// ===== src/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder: front end, job queue and back end.
// Depends on utf8d_pkg, utf8d_front, utf8d_queue, utf8d_back and assert_macros.svh.
//
//   Channel  Direction  Handshake           Payload
//   bytes    in         push / full         data_byte_i, end_of_text_i
//   results  out        empty / pop         code_point_o, malformed_o, last_of_run_o
//
// A byte is taken in every cycle while the job queue has room. The back end hands out
// one result per cycle while pop is high, so a byte causing n results holds the output
// until all n are popped; replacement bursts and a held pop fill the queue.
// A taken byte's results pass through the job queue and the back end's output register.
// Reset is asynchronous and clears the pending sequence, the queue and the output.
`include "assert_macros.svh"

module utf8_stream_decoder import utf8d_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  logic [7:0]     data_byte_i,
  input  logic           end_of_text_i,
  output logic           empty,
  input  logic           pop,
  output logic [CpW-1:0] code_point_o,
  output logic           malformed_o,
  output logic           last_of_run_o
);

  logic      take;
  job_t      wr_job, rd_job;
  logic      job_v, q_rd;
  q_status_t q_status;

  assign full = q_status.full;
  assign take = push && !q_status.full;

  utf8d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .data_byte_i   (data_byte_i),
    .end_of_text_i (end_of_text_i),
    .job_o         (wr_job),
    .job_v_o       (job_v)
  );

  utf8d_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (job_v),
    .wr_job_i (wr_job),
    .rd_i     (q_rd),
    .rd_job_o (rd_job),
    .status_o (q_status)
  );

  utf8d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (rd_job),
    .q_status_i    (q_status),
    .q_rd_o        (q_rd),
    .pop           (pop),
    .empty         (empty),
    .code_point_o  (code_point_o),
    .malformed_o   (malformed_o),
    .last_of_run_o (last_of_run_o)
  );

  `ASSERT_NEVER(a_queue_no_overflow, job_v && q_status.full, "job written into a full queue")
  `ASSERT_NEVER(a_queue_no_underflow, q_rd && !q_status.valid, "job read from an empty queue")
  `ASSERT_CHECK(a_eot_gives_result, take && end_of_text_i |-> job_v, "end of text without result")
  `ASSERT_CHECK(a_bad_value, !empty && malformed_o |-> code_point_o == Replacement, "bad value")

endmodule

// ===== verif/utf8_checker.sv =====
`timescale 1ns / 100ps
// Checker for the UTF-8 stream decoder: watches both channels, predicts the code points
// each accepted byte yields and compares every result transfer with the prediction.
// Depends on utf8d_pkg for the width, the masks and the tags.
module utf8_checker import utf8d_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic           full_i,
  input  logic [7:0]     data_byte_i,
  input  logic           end_of_text_i,
  input  logic           empty_i,
  input  logic           pop_i,
  input  logic [CpW-1:0] code_point_i,
  input  logic           malformed_i,
  input  logic           last_of_run_i,
  output int             failures_o,
  output int             outstanding_o,
  output int             results_o,
  output int             replacements_o
);

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           malformed;
    logic           last_of_run;
  } decoded_t;

  decoded_t       expected_cps[$];
  logic [2:0]     seq_len;
  logic [1:0]     cont_seen;
  logic [CpW-1:0] partial_cp;

  function automatic void decode_byte(input logic [7:0] b, input logic eot);
    decoded_t       burst[$];
    logic           fresh;
    logic [2:0]     seen;
    logic [2:0]     len;
    logic [CpW-1:0] joined;
    logic [CpW-1:0] lead_cp;
    int             reps;
    fresh = 1'b1;
    if (seq_len != LenNone) begin
      if ((b & MaskC0) == ContTag) begin
        fresh = 1'b0;
        seen = 3'(cont_seen) + 3'd1;
        joined = {partial_cp[CpW-7:0], b[5:0]};
        if (seen + 3'd1 >= seq_len) begin
          burst.push_back('{joined, 1'b0, 1'b0});
          {seq_len, cont_seen, partial_cp} = '0;
        end else if (eot) begin
          repeat (seen + 1) burst.push_back('{Replacement, 1'b1, 1'b0});
          {seq_len, cont_seen, partial_cp} = '0;
        end else begin
          cont_seen = seen[1:0];
          partial_cp = joined;
        end
      end else begin
        reps = (cont_seen > 2) ? 2 : cont_seen;
        repeat (reps + 1) burst.push_back('{Replacement, 1'b1, 1'b0});
        {seq_len, cont_seen, partial_cp} = '0;
      end
    end
    if (fresh) begin
      if (!b[7]) begin
        burst.push_back('{CpW'(b), 1'b0, 1'b0});
      end else begin
        lead_cp = '0;
        if ((b & MaskE0) == Lead2Tag) begin
          len = Len2;
          lead_cp = CpW'(b & Payload5);
        end else if ((b & MaskF0) == Lead3Tag) begin
          len = Len3;
          lead_cp = CpW'(b & Payload4);
        end else if ((b & MaskF8) == Lead4Tag) begin
          len = Len4;
          lead_cp = CpW'(b & Payload3);
        end else begin
          len = LenNone;
        end
        if (len == LenNone || eot) begin
          burst.push_back('{Replacement, 1'b1, 1'b0});
        end else begin
          seq_len = len;
          cont_seen = '0;
          partial_cp = lead_cp;
        end
      end
    end
    if (eot) {seq_len, cont_seen, partial_cp} = '0;
    if (burst.size() > 0) burst[burst.size() - 1].last_of_run = 1'b1;
    foreach (burst[k]) expected_cps.push_back(burst[k]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    decoded_t want;
    if (!rst_ni) begin
      {seq_len, cont_seen, partial_cp} = '0;
      expected_cps.delete();
      failures_o = 0;
      outstanding_o = 0;
      results_o = 0;
      replacements_o = 0;
    end else begin
      if (pop_i && !empty_i) begin
        results_o++;
        if (malformed_i) replacements_o++;
        if (expected_cps.size() == 0) begin
          $error("Result transfer with nothing expected: code_point %h", code_point_i);
          failures_o++;
        end else begin
          want = expected_cps.pop_front();
          if (code_point_i !== want.code_point) begin
            $error("code_point: expected %h, got %h", want.code_point, code_point_i);
            failures_o++;
          end
          if (malformed_i !== want.malformed) begin
            $error("malformed: expected %b, got %b", want.malformed, malformed_i);
            failures_o++;
          end
          if (last_of_run_i !== want.last_of_run) begin
            $error("last_of_run: expected %b, got %b", want.last_of_run, last_of_run_i);
            failures_o++;
          end
        end
      end
      if (push_i && !full_i) decode_byte(data_byte_i, end_of_text_i);
      outstanding_o = expected_cps.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Top of the UTF-8 stream decoder testbench: clock, reset, byte stimulus, result stalls,
// watchdog and verdict. Depends on utf8d_pkg, the decoder RTL and utf8_checker.
module testbench;
  import utf8d_pkg::*;

  localparam int unsigned RandomItems = 185;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles = 8;

  // Bit 8 marks the end of the text.
  localparam logic [8:0] DirectedText [27] = '{
    9'h000, 9'h07F, 9'h0DF, 9'h0BF, 9'h0E2, 9'h082, 9'h0AC, 9'h0F7, 9'h0BF,
    9'h0BF, 9'h0BF, 9'h0F8, 9'h0FF, 9'h080, 9'h0E2, 9'h082, 9'h041, 9'h0F4,
    9'h08F, 9'h1BF, 9'h1C3, 9'h0F0, 9'h090, 9'h080, 9'h041, 9'h0C3, 9'h1A9
  };

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           push = 1'b0;
  logic           full;
  logic [7:0]     data_byte = '0;
  logic           end_of_text = 1'b0;
  logic           empty;
  logic           pop = 1'b0;
  logic [CpW-1:0] code_point;
  logic           malformed;
  logic           last_of_run;

  int failures;
  int outstanding;
  int results;
  int replacements;
  int bytes_sent = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;
  bit hold_request = 1'b0;

  always #6 clk_i = ~clk_i;

  utf8_stream_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .data_byte_i   (data_byte),
    .end_of_text_i (end_of_text),
    .empty         (empty),
    .pop           (pop),
    .code_point_o  (code_point),
    .malformed_o   (malformed),
    .last_of_run_o (last_of_run)
  );

  utf8_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .data_byte_i    (data_byte),
    .end_of_text_i  (end_of_text),
    .empty_i        (empty),
    .pop_i          (pop),
    .code_point_i   (code_point),
    .malformed_i    (malformed),
    .last_of_run_i  (last_of_run),
    .failures_o     (failures),
    .outstanding_o  (outstanding),
    .results_o      (results),
    .replacements_o (replacements)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Watchdog: no transfer in %0d cycles", quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] value, input logic last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    push <= 1'b1;
    data_byte <= value;
    end_of_text <= last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        pop <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    logic [7:0] word[$];
    logic [7:0] lead;
    logic [7:0] breaker;
    logic [2:0] len;
    int         kind;
    int         ncont;
    int         random_sent;
    bit         hold_done;
    bit         pause_done;
    hold_done = 1'b0;
    pause_done = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (DirectedText[i]) send_byte(DirectedText[i][7:0], DirectedText[i][8]);
    random_sent = 0;
    while (random_sent < RandomItems) begin
      if (!hold_done && random_sent >= 60) begin
        hold_request = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && random_sent >= 120) begin
        push <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk_i);
        pause_done = 1'b1;
      end
      if (random_sent >= 150) calm = 1'b1;
      word.delete();
      kind = $urandom_range(0, 9);
      len = 3'($urandom_range(2, 4));
      case (len)
        Len2:    lead = Lead2Tag | (8'($urandom) & Payload5);
        Len3:    lead = Lead3Tag | (8'($urandom) & Payload4);
        default: lead = Lead4Tag | (8'($urandom) & Payload3);
      endcase
      if (kind < 2) begin
        word.push_back(8'($urandom_range(0, 127)));
      end else if (kind == 9) begin
        word.push_back(8'($urandom));
      end else begin
        word.push_back(lead);
        ncont = (kind < 7) ? len - 1 : $urandom_range(0, len - 2);
        repeat (ncont) word.push_back(ContTag | (8'($urandom) & Payload6));
        if (kind >= 7) begin
          breaker = 8'($urandom);
          if ((breaker & MaskC0) == ContTag) breaker[6] = 1'b1;
          word.push_back(breaker);
        end
      end
      foreach (word[k]) begin
        send_byte(word[k], ($urandom_range(0, 29) == 0) ||
                           (k == word.size() - 1 && $urandom_range(0, 7) == 0));
        random_sent++;
      end
    end
    push <= 1'b0;
    wait (outstanding == 0);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Decoded %0d bytes into %0d code points, %0d of them replacements,",
             bytes_sent, results, replacements);
    $display("with stalls on both sides, a filled queue and a pause to drain.");
    if (failures == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
